>>> sv/lpq_pkg.sv
// ============================================================================
// lpq_pkg: shared definitions for the linked priority queue
// Command and status codes, compare modes, and the control and status
// structs that join the controller to the datapath.
// ============================================================================
`timescale 1ns / 1ps

package lpq_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int DATA_W       = 32;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_TOP   = 2'd2,
        CMD_EMPTY = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_LT = 2'd0,
        MODE_LE = 2'd1,
        MODE_GT = 2'd2,
        MODE_GE = 2'd3
    } mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    init_wr;
        logic    capture;
        logic    push_rd;
        logic    push_wr;
        logic    walk_start;
        logic    walk_step;
        logic    unlink_a;
        logic    unlink_b;
        logic    res_load;
        status_t res_status;
        logic    res_data;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic      init_done;
        logic      full;
        logic      empty;
        logic      walk_last;
        cmd_code_t cmd;
    } stat_t;

    // True when the candidate priority beats the current best.
    function automatic logic beats(input logic signed [DATA_W-1:0] cand,
                                   input logic signed [DATA_W-1:0] best,
                                   input mode_t mode);
        logic r;
        case (mode)
            MODE_LT: r = (cand < best);
            MODE_LE: r = (cand <= best);
            MODE_GT: r = (cand > best);
            MODE_GE: r = (cand >= best);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/lpq_if.sv
// ============================================================================
// lpq_if: request and response channels of the linked priority queue
// Valid/ready channels; an item moves at a clock edge with both high.
// ============================================================================
`timescale 1ns / 1ps

interface lpq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] elem_value;
    logic signed [31:0] priority_req;

    modport source (output valid, output command, output elem_value,
                    output priority_req, input ready);
    modport sink   (input valid, input command, input elem_value,
                    input priority_req, output ready);
endinterface

interface lpq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
    logic               is_empty;

    modport source (output valid, output status, output out_value,
                    output out_priority, output is_empty, input ready);
    modport sink   (input valid, input status, input out_value,
                    input out_priority, input is_empty, output ready);
endinterface

>>> sv/lpq_ram.sv
// ============================================================================
// lpq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module lpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/lpq_ctrl.sv
// ============================================================================
// lpq_ctrl: sequencing controller of the linked priority queue
// Steps through link initialization, push, list walk, unlink and response.
// ============================================================================
`timescale 1ns / 1ps

module lpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  lpq_pkg::cmd_code_t req_command,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  lpq_pkg::stat_t    stat,
    output lpq_pkg::ctl_t     ctl
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUSH_WR,
        S_WALK,
        S_UNLINK_A,
        S_UNLINK_B,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    lpq_pkg::status_t      res_status_reg, res_status_next;
    logic                  res_data_reg, res_data_next;

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        ctl             = '0;
        ctl.res_status  = res_status_reg;
        ctl.res_data    = res_data_reg;
        req_ready       = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                if (stat.init_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.init_wr = 1'b1;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    unique case (req_command) inside
                        lpq_pkg::CMD_PUSH:
                        begin
                            if (stat.full)
                            begin
                                res_status_next = lpq_pkg::ST_FULL;
                                res_data_next   = 1'b0;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ctl.push_rd = 1'b1;
                                state_next  = S_PUSH_WR;
                            end
                        end
                        lpq_pkg::CMD_POP, lpq_pkg::CMD_TOP:
                        begin
                            if (stat.empty)
                            begin
                                res_status_next = lpq_pkg::ST_EMPTY;
                                res_data_next   = 1'b0;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ctl.walk_start = 1'b1;
                                state_next     = S_WALK;
                            end
                        end
                        default:
                        begin
                            res_status_next = lpq_pkg::ST_OK;
                            res_data_next   = 1'b0;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end
            S_PUSH_WR:
            begin
                ctl.push_wr     = 1'b1;
                res_status_next = lpq_pkg::ST_OK;
                res_data_next   = 1'b0;
                state_next      = S_RESP;
            end
            S_WALK:
            begin
                ctl.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    res_status_next = lpq_pkg::ST_OK;
                    res_data_next   = 1'b1;
                    state_next      = (stat.cmd == lpq_pkg::CMD_POP) ? S_UNLINK_A : S_RESP;
                end
            end
            S_UNLINK_A:
            begin
                ctl.unlink_a = 1'b1;
                state_next   = S_UNLINK_B;
            end
            S_UNLINK_B:
            begin
                ctl.unlink_b = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (ctl.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            rsp_valid_reg  <= 1'b0;
            res_status_reg <= lpq_pkg::ST_OK;
            res_data_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    // Every accepted item leaves the idle state on the next cycle.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    // A result only appears out of the response state.
    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_RESP))
        else $error("result raised outside the response state");
`endif

endmodule

>>> sv/lpq_dp.sv
// ============================================================================
// lpq_dp: datapath of the linked priority queue
// Node stores, list pointers, walk registers and the result register.
// ============================================================================
`timescale 1ns / 1ps

module lpq_dp #(
    parameter int CAPACITY = lpq_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_wdata,
    input  lpq_pkg::ctl_t                        ctl,
    output lpq_pkg::stat_t                       stat,
    input  lpq_pkg::cmd_code_t                   command,
    input  logic signed [lpq_pkg::DATA_W-1:0]    elem_value,
    input  logic signed [lpq_pkg::DATA_W-1:0]    priority_req,
    output logic [1:0]                           status,
    output logic signed [lpq_pkg::DATA_W-1:0]    out_value,
    output logic signed [lpq_pkg::DATA_W-1:0]    out_priority,
    output logic                                 is_empty
);

    localparam int DW = lpq_pkg::DATA_W;
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL       = {LW{1'b1}};
    localparam logic [LW-1:0] CAP_L     = LW'(CAPACITY);
    localparam logic [LW-1:0] LAST_NODE = LW'(CAPACITY - 1);

    lpq_pkg::mode_t     mode_reg;
    logic [LW-1:0]      init_idx_reg;
    logic [LW-1:0]      head_reg, tail_reg, free_reg, count_reg;
    logic [LW-1:0]      cur_reg, prev_cur_reg, steps_reg;
    logic [LW-1:0]      best_reg, best_prev_reg, best_next_reg;
    logic signed [DW-1:0] best_val_reg, best_prio_reg;
    lpq_pkg::cmd_code_t cmd_reg;
    logic signed [DW-1:0] val_reg, prio_reg;
    lpq_pkg::status_t   out_status_reg;
    logic signed [DW-1:0] out_value_reg, out_prio_reg;
    logic               out_empty_reg;

    // Memory ports.
    logic               lk_we, lk_re;
    logic [IW-1:0]      lk_waddr, rd_addr;
    logic [LW-1:0]      lk_wdata, lk_rdata;
    logic               dt_we;
    logic [2*DW-1:0]    dt_rdata;
    logic signed [DW-1:0] rd_val, rd_prio;
    logic               take;

    assign rd_val  = dt_rdata[2*DW-1:DW];
    assign rd_prio = dt_rdata[DW-1:0];

    assign stat.init_done = (init_idx_reg == CAP_L);
    assign stat.full      = (count_reg == CAP_L);
    assign stat.empty     = (count_reg == '0);
    assign stat.walk_last = (steps_reg == (count_reg - LW'(1)));
    assign stat.cmd       = cmd_reg;

    // The first visited node always becomes the running best.
    assign take = (steps_reg == '0) || lpq_pkg::beats(rd_prio, best_prio_reg, mode_reg);

    always_comb
    begin
        rd_addr = head_reg[IW-1:0];
        lk_re   = 1'b0;
        if (ctl.push_rd)
        begin
            rd_addr = free_reg[IW-1:0];
            lk_re   = 1'b1;
        end
        else if (ctl.walk_start)
        begin
            rd_addr = head_reg[IW-1:0];
            lk_re   = 1'b1;
        end
        else if (ctl.walk_step)
        begin
            rd_addr = lk_rdata[IW-1:0];
            lk_re   = !stat.walk_last;
        end

        lk_we    = 1'b0;
        lk_waddr = free_reg[IW-1:0];
        lk_wdata = NIL;
        if (ctl.init_wr)
        begin
            lk_we    = 1'b1;
            lk_waddr = init_idx_reg[IW-1:0];
            lk_wdata = (init_idx_reg == LAST_NODE) ? NIL : (init_idx_reg + LW'(1));
        end
        else if (ctl.push_rd)
        begin
            // Append: the current tail points at the node being taken.
            lk_we    = (count_reg != '0);
            lk_waddr = tail_reg[IW-1:0];
            lk_wdata = free_reg;
        end
        else if (ctl.push_wr)
        begin
            lk_we    = 1'b1;
            lk_waddr = free_reg[IW-1:0];
            lk_wdata = NIL;
        end
        else if (ctl.unlink_a)
        begin
            lk_we    = (best_prev_reg != NIL);
            lk_waddr = best_prev_reg[IW-1:0];
            lk_wdata = best_next_reg;
        end
        else if (ctl.unlink_b)
        begin
            lk_we    = 1'b1;
            lk_waddr = best_reg[IW-1:0];
            lk_wdata = free_reg;
        end

        dt_we = ctl.push_wr;
    end

    lpq_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (lk_we),
        .wr_addr (lk_waddr),
        .wr_data (lk_wdata),
        .rd_en   (lk_re),
        .rd_addr (rd_addr),
        .rd_data (lk_rdata)
    );

    lpq_ram #(
        .WIDTH (2 * DW),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (dt_we),
        .wr_addr (free_reg[IW-1:0]),
        .wr_data ({val_reg, prio_reg}),
        .rd_en   (lk_re),
        .rd_addr (rd_addr),
        .rd_data (dt_rdata)
    );

    // List pointers and control counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= lpq_pkg::MODE_LT;
            init_idx_reg <= '0;
            head_reg     <= NIL;
            tail_reg     <= NIL;
            free_reg     <= '0;
            count_reg    <= '0;
            steps_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= lpq_pkg::mode_t'(cfg_wdata);
            end
            if (ctl.init_wr)
            begin
                init_idx_reg <= init_idx_reg + LW'(1);
            end
            if (ctl.push_wr)
            begin
                if (count_reg == '0)
                begin
                    head_reg <= free_reg;
                end
                tail_reg  <= free_reg;
                free_reg  <= lk_rdata;
                count_reg <= count_reg + LW'(1);
            end
            else if (ctl.walk_start)
            begin
                steps_reg <= '0;
            end
            else if (ctl.walk_step)
            begin
                steps_reg <= steps_reg + LW'(1);
            end
            else if (ctl.unlink_a)
            begin
                if (head_reg == best_reg)
                begin
                    head_reg <= best_next_reg;
                end
                if (tail_reg == best_reg)
                begin
                    tail_reg <= best_prev_reg;
                end
            end
            else if (ctl.unlink_b)
            begin
                free_reg  <= best_reg;
                count_reg <= count_reg - LW'(1);
                if (count_reg == LW'(1))
                begin
                    head_reg <= NIL;
                    tail_reg <= NIL;
                end
            end
        end
    end

    // Captured item, walk tracking and result payload.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= command;
            val_reg  <= elem_value;
            prio_reg <= priority_req;
        end
        if (ctl.walk_start)
        begin
            cur_reg      <= head_reg;
            prev_cur_reg <= NIL;
        end
        else if (ctl.walk_step)
        begin
            if (take)
            begin
                best_reg      <= cur_reg;
                best_prev_reg <= prev_cur_reg;
                best_next_reg <= lk_rdata;
                best_val_reg  <= rd_val;
                best_prio_reg <= rd_prio;
            end
            prev_cur_reg <= cur_reg;
            cur_reg      <= lk_rdata;
        end
        if (ctl.res_load)
        begin
            out_status_reg <= ctl.res_status;
            out_value_reg  <= ctl.res_data ? best_val_reg : '0;
            out_prio_reg   <= ctl.res_data ? best_prio_reg : '0;
            out_empty_reg  <= (count_reg == '0);
        end
    end

    assign status       = out_status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;
    assign is_empty     = out_empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_L)
        else $error("node count exceeds the store");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load |-> ((count_reg == '0) == (head_reg == NIL)))
        else $error("head pointer disagrees with node count");

    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.walk_step |-> (steps_reg < count_reg))
        else $error("walk went past the end of the list");

    a_push_has_node: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push_wr |-> ((free_reg != NIL) && (count_reg < CAP_L)))
        else $error("push took a node from an exhausted free chain");
`endif

endmodule

>>> sv/linked_priority_queue.sv
// ============================================================================
// linked_priority_queue: priority queue kept as a linked list of nodes
// Top and pop walk all queued entries, reading one linked node per cycle
// from the link RAM; push, query empty and empty or full rejects need no
// walk. The queue works on one item at a time.
// Reset: after rst_n the free chain is built one node per cycle; no item is
// taken until it is built, while configuration writes are taken always.
// ============================================================================
`timescale 1ns / 1ps

module linked_priority_queue #(
    parameter int CAPACITY = lpq_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    lpq_req_if.sink    req,
    lpq_rsp_if.source  rsp
);

    // The controller sequences each item; the datapath holds the node stores,
    // the list pointers (head, tail, free chain head, count) and the walk
    // registers. Nodes live in a link RAM (next pointers) and a data RAM
    // (value and priority side by side). Pop needs the predecessor of the
    // winning node, which the walk records as it goes, so no backward links
    // are stored.
    lpq_pkg::ctl_t  ctl;
    lpq_pkg::stat_t stat;

    lpq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (lpq_pkg::cmd_code_t'(req.command)),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .stat        (stat),
        .ctl         (ctl)
    );

    // The result register in the datapath lets a new item start while the
    // previous result still waits to be taken.
    lpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .ctl          (ctl),
        .stat         (stat),
        .command      (lpq_pkg::cmd_code_t'(req.command)),
        .elem_value   (req.elem_value),
        .priority_req (req.priority_req),
        .status       (rsp.status),
        .out_value    (rsp.out_value),
        .out_priority (rsp.out_priority),
        .is_empty     (rsp.is_empty)
    );

endmodule
